### rtl/core/gbw_pkg.sv
// Shared types, constants and helper functions for the Gaussian blur window.
`timescale 1ns / 1ps
package gbw_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 12;
    localparam int FH_W       = 13;
    localparam int ROW_W      = 14;
    localparam int SLOT_W     = 3;
    localparam int WC_W       = 17;
    localparam int WD_W       = 16;
    localparam int WW_W       = 2 * WC_W;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CTR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THREE = 3'd5;

    // Input item codes
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0] frame_width;
        logic [FH_W-1:0]  frame_height;
        logic [WC_W-1:0]  weight_center;
        logic [WD_W-1:0]  weight_one;
        logic [WD_W-1:0]  weight_two;
        logic [WD_W-1:0]  weight_three;
    } cfg_t;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel;
    } pix_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] blurred_pixel;
        logic             last_of_frame;
    } blur_item_t;

    // Work for the back end: an optional line-store write and an optional result
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [COL_W-1:0]  wr_col;
        logic [PIX_W-1:0]  wr_data;
        logic              emit;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic [SLOT_W-1:0] out_slot;
        logic              last;
    } job_t;

    function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] fw,
                                                   input int unsigned max_w);
        logic [COL_W-1:0] res;
        if (fw == '0)
            res = COL_W'(1);
        else if (32'(fw) > max_w)
            res = COL_W'(max_w);
        else
            res = fw;
        return res;
    endfunction

    function automatic logic [FH_W-1:0] eff_height(input logic [FH_W-1:0] fh);
        return (fh == '0) ? FH_W'(1) : fh;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                   input logic [SLOT_W-1:0] top);
        return (s == top) ? '0 : SLOT_W'(s + 1'b1);
    endfunction

    function automatic logic [WC_W-1:0] weight_at(input cfg_t c, input logic [1:0] d);
        logic [WC_W-1:0] res;
        unique case (d)
            2'd0:    res = c.weight_center;
            2'd1:    res = {1'b0, c.weight_one};
            2'd2:    res = {1'b0, c.weight_two};
            default: res = {1'b0, c.weight_three};
        endcase
        return res;
    endfunction

endpackage

### rtl/core/gbw_chan_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
`timescale 1ns / 1ps
interface gbw_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/gbw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/gbw_fifo.sv
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps
module gbw_fifo import gbw_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    input  logic pop,
    output job_t dout,
    output logic full,
    output logic nonempty
);
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign dout     = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end
endmodule

### rtl/core/gbw_front.sv
// Front end: accepts items, tracks frame positions and decides writes and results.
`timescale 1ns / 1ps
module gbw_front import gbw_pkg::*; #(
    parameter int HALF      = 2,
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    gbw_chan_if.sink    pix,
    output job_t        job,
    output logic        push,
    input  logic        full
);
    localparam int WIN   = 2 * HALF + 1;
    localparam int LIN_W = ROW_W + COL_W + 2;
    localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WIN - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_CMP  = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [COL_W-1:0]  w;
    logic [FH_W-1:0]   h;
    logic [ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic              wr_en_reg, wr_en_next;
    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [COL_W-1:0]  wr_col_reg, wr_col_next;
    logic [PIX_W-1:0]  wr_data_reg, wr_data_next;
    logic [ROW_W+COL_W-1:0] cons_mul;
    logic [ROW_W+COL_W:0]   lim_mul;
    logic [ROW_W:0]         lim_row;
    logic [LIN_W-1:0]  cons_reg, lim_reg;
    logic              emit, last;

    assign w = eff_width(cfg.frame_width, MAX_WIDTH);
    assign h = eff_height(cfg.frame_height);

    assign pix.ready = (state_reg == F_IDLE);

    // Linear input and output positions plus lag
    assign cons_mul = in_row_reg * w;
    assign lim_row  = {1'b0, out_row_reg} + (ROW_W+1)'(HALF);
    assign lim_mul  = lim_row * w;

    assign emit = (cons_reg > lim_reg);
    assign last = (out_row_reg == ROW_W'(h) - ROW_W'(1)) && (out_col_reg == w - COL_W'(1));

    assign job  = '{wr_en: wr_en_reg, wr_slot: wr_slot_reg, wr_col: wr_col_reg,
                    wr_data: wr_data_reg, emit: emit, out_row: out_row_reg,
                    out_col: out_col_reg, out_slot: out_slot_reg, last: last};
    assign push = (state_reg == F_CMP) && !full;

    always_comb
    begin
        state_next    = state_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        wr_en_next    = wr_en_reg;
        wr_slot_next  = wr_slot_reg;
        wr_col_next   = wr_col_reg;
        wr_data_next  = wr_data_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (pix.valid)
                begin
                    // Wrap the output position, restart the frame if it ran off
                    if (out_col_next >= w)
                    begin
                        out_col_next  = '0;
                        out_row_next  = ROW_W'(out_row_next + 1'b1);
                        out_slot_next = slot_inc(out_slot_next, SLOT_TOP);
                    end
                    if (out_row_next >= ROW_W'(h))
                    begin
                        out_row_next  = '0;
                        out_col_next  = '0;
                        out_slot_next = '0;
                        in_row_next   = '0;
                        in_col_next   = '0;
                        in_slot_next  = '0;
                    end
                    if (in_col_next >= w)
                    begin
                        in_col_next  = '0;
                        in_row_next  = ROW_W'(in_row_next + 1'b1);
                        in_slot_next = slot_inc(in_slot_next, SLOT_TOP);
                    end
                    // Line-store write for items inside the frame
                    wr_en_next   = (in_row_next < ROW_W'(h));
                    wr_slot_next = in_slot_next;
                    wr_col_next  = in_col_next;
                    wr_data_next = (pix.data.func == FUNC_FLUSH) ? '0 : pix.data.pixel;
                    // Advance the input position
                    in_col_next = COL_W'(in_col_next + 1'b1);
                    if (in_col_next >= w)
                    begin
                        in_col_next  = '0;
                        in_row_next  = ROW_W'(in_row_next + 1'b1);
                        in_slot_next = slot_inc(in_slot_next, SLOT_TOP);
                    end
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_CMP;
            end
            F_CMP:
            begin
                if (!full)
                begin
                    if (emit && last)
                    begin
                        out_row_next  = '0;
                        out_col_next  = '0;
                        out_slot_next = '0;
                        in_row_next   = '0;
                        in_col_next   = '0;
                        in_slot_next  = '0;
                    end
                    else if (emit)
                    begin
                        out_col_next = COL_W'(out_col_reg + 1'b1);
                        if (out_col_next >= w)
                        begin
                            out_col_next  = '0;
                            out_row_next  = ROW_W'(out_row_reg + 1'b1);
                            out_slot_next = slot_inc(out_slot_reg, SLOT_TOP);
                        end
                    end
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            wr_en_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            wr_en_reg    <= wr_en_next;
        end
    end

    // Payload and position products
    always_ff @(posedge clk)
    begin
        wr_slot_reg <= wr_slot_next;
        wr_col_reg  <= wr_col_next;
        wr_data_reg <= wr_data_next;
        if (state_reg == F_MUL)
        begin
            cons_reg <= LIN_W'(cons_mul) + LIN_W'(in_col_reg);
            lim_reg  <= LIN_W'(lim_mul) + LIN_W'(out_col_reg) + LIN_W'(HALF);
        end
    end
endmodule

### rtl/core/gbw_back.sv
// Back end: writes the line store and runs the window multiply-accumulate.
`timescale 1ns / 1ps
module gbw_back import gbw_pkg::*; #(
    parameter int HALF      = 2,
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  job_t        job,
    input  logic        job_valid,
    output logic        pop,
    gbw_chan_if.source  blur
);
    localparam int WIN   = 2 * HALF + 1;
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int SB    = $clog2(WIN);
    localparam int DEPTH = WIN << CB;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [SLOT_W-1:0]  TAP_TOP = SLOT_W'(2 * HALF);
    localparam logic [SLOT_W-1:0]  HALF_D  = SLOT_W'(HALF);
    localparam logic [ROW_W:0]     HALF_R  = (ROW_W+1)'(HALF);
    localparam logic [COL_W:0]     HALF_C  = (COL_W+1)'(HALF);
    localparam logic [SLOT_W+1:0]  WIN_S   = (SLOT_W+2)'(WIN);
    localparam logic [SLOT_W+1:0]  SLOT_OFS = (SLOT_W+2)'(WIN - HALF);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_TAPS  = 4'b0010,
        B_DRAIN = 4'b0100,
        B_DONE  = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [COL_W-1:0]  w;
    logic [FH_W-1:0]   h;
    job_t              cur_reg;
    logic [SLOT_W-1:0] dr_reg, dc_reg;
    logic [ROW_W:0]    rr;
    logic [COL_W:0]    cc, col, wcol;
    logic [SLOT_W+1:0] slot;
    logic [SLOT_W-1:0] dist_r, dist_c;
    logic              tap_ok, issue;
    logic [WW_W-1:0]   ww, ww_reg;
    logic              s1_live_reg, s2_live_reg;
    logic [PIX_W+WW_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [PIX_W-1:0]  rdata;
    logic              load;
    logic              blur_vld_reg;
    blur_item_t        blur_data_reg;
    logic [ACC_W-33:0] whole;

    assign w = eff_width(cfg.frame_width, MAX_WIDTH);
    assign h = eff_height(cfg.frame_height);

    // Line-store write from the head job, taken as it is popped
    assign pop   = (state_reg == B_IDLE) && job_valid;
    assign we    = pop && job.wr_en;
    assign wcol  = {1'b0, job.wr_col};
    assign waddr = {job.wr_slot[SB-1:0], wcol[CB-1:0]};

    // Tap position, range check, line-store slot and 2D weight
    always_comb
    begin
        rr     = {1'b0, cur_reg.out_row} + (ROW_W+1)'(dr_reg);
        cc     = {1'b0, cur_reg.out_col} + (COL_W+1)'(dc_reg);
        col    = cc - HALF_C;
        tap_ok = (rr >= HALF_R) && ((rr - HALF_R) < (ROW_W+1)'(h))
              && (cc >= HALF_C) && (col < (COL_W+1)'(w));
        slot   = (SLOT_W+2)'(cur_reg.out_slot) + (SLOT_W+2)'(dr_reg) + SLOT_OFS;
        if (slot >= WIN_S)
            slot = slot - WIN_S;
        if (slot >= WIN_S)
            slot = slot - WIN_S;
        dist_r = (dr_reg >= HALF_D) ? dr_reg - HALF_D : HALF_D - dr_reg;
        dist_c = (dc_reg >= HALF_D) ? dc_reg - HALF_D : HALF_D - dc_reg;
        ww     = weight_at(cfg, dist_r[1:0]) * weight_at(cfg, dist_c[1:0]);
    end

    assign raddr = {slot[SB-1:0], col[CB-1:0]};
    assign issue = (state_reg == B_TAPS);

    gbw_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_row_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (job.wr_data),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign load  = (state_reg == B_DONE) && (!blur_vld_reg || blur.ready);
    assign whole = acc_reg[ACC_W-1:32];

    assign blur.valid = blur_vld_reg;
    assign blur.data  = blur_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid && job.emit)
                    state_next = B_TAPS;
            end
            B_TAPS:
            begin
                if (dr_reg == TAP_TOP && dc_reg == TAP_TOP)
                    state_next = B_DRAIN;
            end
            B_DRAIN:
            begin
                if (!s1_live_reg && !s2_live_reg)
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (load)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state and pipeline flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            dr_reg       <= '0;
            dc_reg       <= '0;
            s1_live_reg  <= 1'b0;
            s2_live_reg  <= 1'b0;
            blur_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            s1_live_reg <= issue && tap_ok;
            s2_live_reg <= s1_live_reg;
            // Step through the window, columns innermost
            if (pop)
            begin
                dr_reg <= '0;
                dc_reg <= '0;
            end
            else if (issue)
            begin
                if (dc_reg == TAP_TOP)
                begin
                    dc_reg <= '0;
                    dr_reg <= SLOT_W'(dr_reg + 1'b1);
                end
                else
                begin
                    dc_reg <= SLOT_W'(dc_reg + 1'b1);
                end
            end
            // Hold the result until its transfer
            if (load)
                blur_vld_reg <= 1'b1;
            else if (blur.ready)
                blur_vld_reg <= 1'b0;
        end
    end

    // Multiply-accumulate datapath and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= job;
        ww_reg   <= ww;
        prod_reg <= rdata * ww_reg;
        if (pop)
            acc_reg <= '0;
        else if (s2_live_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (load)
        begin
            blur_data_reg.blurred_pixel <= (|whole[ACC_W-33:PIX_W]) ? '1 : whole[PIX_W-1:0];
            blur_data_reg.last_of_frame <= cur_reg.last;
        end
    end
endmodule

### rtl/core/gaussian_blur_window.sv
// Each item passes the front end's multiply and compare states into the job queue;
// a job with a result then holds the back end in its tap, drain and done states,
// one window tap a cycle through the single line-store read port and shared
// multiply-accumulate; neither end takes new work before the last is through.
// Reset: positions cleared, configuration at defaults, line store left unwritten.
`timescale 1ns / 1ps
module gaussian_blur_window import gbw_pkg::*; #(
    parameter int HALF      = 2,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gbw_chan_if.sink              pixel_chan,
    gbw_chan_if.source            blur_chan
);
    cfg_t cfg_reg;
    job_t q_din, q_dout;
    logic q_push, q_pop, q_full, q_nonempty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= COL_W'(640);
            cfg_reg.frame_height  <= FH_W'(480);
            cfg_reg.weight_center <= WC_W'(26386);
            cfg_reg.weight_one    <= WD_W'(16003);
            cfg_reg.weight_two    <= WD_W'(3571);
            cfg_reg.weight_three  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width   <= cfg_data[COL_W-1:0];
                CFG_FRAME_HEIGHT: cfg_reg.frame_height  <= cfg_data[FH_W-1:0];
                CFG_WEIGHT_CTR:   cfg_reg.weight_center <= cfg_data[WC_W-1:0];
                CFG_WEIGHT_ONE:   cfg_reg.weight_one    <= cfg_data[WD_W-1:0];
                CFG_WEIGHT_TWO:   cfg_reg.weight_two    <= cfg_data[WD_W-1:0];
                CFG_WEIGHT_THREE: cfg_reg.weight_three  <= cfg_data[WD_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    gbw_front #(.HALF(HALF), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .pix   (pixel_chan),
        .job   (q_din),
        .push  (q_push),
        .full  (q_full)
    );

    gbw_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .din      (q_din),
        .pop      (q_pop),
        .dout     (q_dout),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    gbw_back #(.HALF(HALF), .MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (q_dout),
        .job_valid (q_nonempty),
        .pop       (q_pop),
        .blur      (blur_chan)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nonempty)
        else $error("job queue read while empty");

    a_push_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> !q_full)
        else $error("job queue still full after a read");
`endif
endmodule

### tb/gbw_blur_checker.sv
// Watches both channels and the register port, predicts each blurred pixel and compares.
`timescale 1ns / 1ps
module gbw_blur_checker import gbw_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gbw_chan_if                   pix_mon,
    gbw_chan_if                   blur_mon,
    output int                    fail_count,
    output int                    pending
);
    localparam int WIN       = 5;
    localparam int HALF_WIN  = 2;
    localparam int LINE_MAX  = 2048;

    logic [PIX_W-1:0] line_mem [0:WIN*LINE_MAX-1];
    int unsigned      in_row, in_col, out_row, out_col;
    logic [COL_W-1:0] frame_width;
    logic [FH_W-1:0]  frame_height;
    logic [WC_W-1:0]  wt_ctr;
    logic [WD_W-1:0]  wt_one, wt_two, wt_three;
    blur_item_t       blur_expected [$];

    function automatic longint unsigned tap_weight(input int unsigned tap_dist);
        case (tap_dist)
            0:       return wt_ctr;
            1:       return wt_one;
            2:       return wt_two;
            3:       return wt_three;
            default: return 0;
        endcase
    endfunction

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Advance the line store and positions by one pixel transfer
    task automatic blur_predict(input pix_item_t item);
        int unsigned       w, h, r, c;
        longint unsigned   consumed, out_lin, lag, acc;
        int                dr, dc;
        bit                last;
        blur_item_t        res;
        w = (frame_width == 0) ? 1 : ((frame_width > LINE_MAX) ? LINE_MAX : frame_width);
        h = (frame_height == 0) ? 1 : frame_height;
        if (out_col >= w) begin out_col = 0; out_row++; end
        if (out_row >= h) begin in_row = 0; in_col = 0; out_row = 0; out_col = 0; end
        if (in_col >= w) begin in_col = 0; in_row++; end
        if (in_row < h)
            line_mem[(in_row % WIN) * LINE_MAX + in_col] =
                (item.func == FUNC_PIXEL) ? item.pixel : '0;
        in_col++;
        if (in_col >= w) begin in_col = 0; in_row++; end
        consumed = longint'(in_row) * w + in_col;
        out_lin  = longint'(out_row) * w + out_col;
        lag      = HALF_WIN * w + HALF_WIN;
        if (consumed > out_lin + lag) begin
            acc = 0;
            for (dr = -HALF_WIN; dr <= HALF_WIN; dr++) begin
                for (dc = -HALF_WIN; dc <= HALF_WIN; dc++) begin
                    if (int'(out_row) + dr >= 0 && int'(out_row) + dr < int'(h) &&
                        int'(out_col) + dc >= 0 && int'(out_col) + dc < int'(w)) begin
                        r = out_row + dr;
                        c = out_col + dc;
                        acc += longint'(line_mem[(r % WIN) * LINE_MAX + c])
                             * tap_weight(dr < 0 ? -dr : dr)
                             * tap_weight(dc < 0 ? -dc : dc);
                    end
                end
            end
            acc = acc >> 32;
            res.blurred_pixel = (acc > 255) ? 8'd255 : acc[7:0];
            last = (out_row == h - 1) && (out_col == w - 1);
            res.last_of_frame = last;
            blur_expected.push_back(res);
            if (last) begin
                in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            end
            else begin
                out_col++;
                if (out_col >= w) begin out_col = 0; out_row++; end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        blur_item_t got, want;
        if (!rst_n) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            frame_width  = 640;
            frame_height = 480;
            wt_ctr = 26386; wt_one = 16003; wt_two = 3571; wt_three = 0;
            fail_count = 0;
            blur_expected.delete();
        end
        else begin
            // Mirror register writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width  = cfg_data[COL_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height = cfg_data[FH_W-1:0];
                    CFG_WEIGHT_CTR:   wt_ctr       = cfg_data[WC_W-1:0];
                    CFG_WEIGHT_ONE:   wt_one       = cfg_data[WD_W-1:0];
                    CFG_WEIGHT_TWO:   wt_two       = cfg_data[WD_W-1:0];
                    CFG_WEIGHT_THREE: wt_three     = cfg_data[WD_W-1:0];
                    default: ;
                endcase
            end
            if (pix_mon.valid && pix_mon.ready)
                blur_predict(pix_mon.data);
            // Compare each output transfer with the oldest expectation
            if (blur_mon.valid && blur_mon.ready) begin
                got = blur_mon.data;
                if (blur_expected.size() == 0)
                    report($sformatf("unexpected output pix=%0d last=%0b",
                                     got.blurred_pixel, got.last_of_frame));
                else begin
                    want = blur_expected.pop_front();
                    if (got.blurred_pixel !== want.blurred_pixel)
                        report($sformatf("blurred_pixel got %0d want %0d",
                                         got.blurred_pixel, want.blurred_pixel));
                    if (got.last_of_frame !== want.last_of_frame)
                        report($sformatf("last_of_frame got %0b want %0b",
                                         got.last_of_frame, want.last_of_frame));
                end
            end
        end
        pending = blur_expected.size();
    end
endmodule

### tb/tb_gaussian_blur_window.sv
// Top of the blur testbench: clock, reset, stimulus, back-pressure and the verdict.
`timescale 1ns / 1ps
module tb_gaussian_blur_window;
    import gbw_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    calm;
    bit                    hold_armed;
    int                    hold_left;
    int                    sent;

    gbw_chan_if #(.T(pix_item_t))  pixel_chan ();
    gbw_chan_if #(.T(blur_item_t)) blur_chan ();

    gaussian_blur_window u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_chan (pixel_chan),
        .blur_chan  (blur_chan)
    );

    gbw_blur_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_mon    (pixel_chan),
        .blur_mon   (blur_chan),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: random stalls, one long hold-off when armed
    initial
    begin
        blur_chan.ready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                hold_left  = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                blur_chan.ready <= 1'b0;
            end
            else
                blur_chan.ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    // Hard stop for a hung run
    initial
    begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned wc, input int unsigned w1,
                                input int unsigned w2, input int unsigned w3);
        cfg_write(CFG_FRAME_WIDTH, w);
        cfg_write(CFG_FRAME_HEIGHT, h);
        cfg_write(CFG_WEIGHT_CTR, wc);
        cfg_write(CFG_WEIGHT_ONE, w1);
        cfg_write(CFG_WEIGHT_TWO, w2);
        cfg_write(CFG_WEIGHT_THREE, w3);
    endtask

    task automatic send_item(input logic f, input logic [PIX_W-1:0] p);
        pix_item_t item;
        item.func  = f;
        item.pixel = p;
        while (!calm && $urandom_range(0, 99) < 15) begin
            pixel_chan.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_chan.valid <= 1'b1;
        pixel_chan.data  <= item;
        do @(posedge clk); while (!pixel_chan.ready);
        sent++;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One full frame, then enough flush transfers to drain it; then wait for idle
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned flush_pct);
        int unsigned ew, eh, n;
        ew = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
        eh = (h == 0) ? 1 : h;
        for (n = 0; n < ew * eh; n++) begin
            if ($urandom_range(0, 99) < flush_pct)
                send_item(FUNC_FLUSH, PIX_W'($urandom_range(0, 255)));
            else
                send_item(FUNC_PIXEL, rand_pixel());
        end
        for (n = 0; n < 2 * ew + 2; n++)
            send_item(FUNC_FLUSH, PIX_W'($urandom_range(0, 255)));
        pixel_chan.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic int unsigned rand_wt(input int unsigned top);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    initial
    begin
        int unsigned w, h;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        pixel_chan.valid = 1'b0;
        pixel_chan.data  = '0;
        calm             = 1'b0;
        hold_armed       = 1'b0;
        sent             = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed: small frame, default weights, extremes and an in-frame flush
        set_geometry(4, 3, 26386, 16003, 3571, 0);
        send_item(FUNC_PIXEL, 8'd255);
        send_item(FUNC_PIXEL, 8'd0);
        send_item(FUNC_FLUSH, 8'd255);
        send_item(FUNC_PIXEL, 8'd255);
        for (int i = 0; i < 8; i++)
            send_item(FUNC_PIXEL, (i % 2) ? 8'd255 : 8'd170);
        for (int i = 0; i < 10; i++)
            send_item(FUNC_FLUSH, 8'd85);
        pixel_chan.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        // Saturating weights, zero width and height
        set_geometry(0, 0, 65536, 32768, 32768, 32768);
        run_frame(0, 0, 0);
        set_geometry(3, 2, 65536, 32768, 32768, 65535);
        run_frame(3, 2, 0);
        set_geometry(5, 1, 0, 0, 0, 0);
        run_frame(5, 1, 10);

        // Wider frame with no idling on either side
        calm = 1'b1;
        set_geometry(40, 6, 26386, 16003, 3571, 12345);
        run_frame(40, 6, 2);
        calm = 1'b0;

        // Random frames; first one with a long output hold-off
        hold_armed = 1'b1;
        while (sent < 1150) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
            calm = ($urandom_range(0, 4) == 0);
            set_geometry(w, h, rand_wt(65536), rand_wt(32768), rand_wt(32768),
                         rand_wt(32768));
            run_frame(w, h, $urandom_range(0, 1) ? 0 : 15);
        end

        // Restore reset defaults once more
        set_geometry(640, 480, 26386, 16003, 3571, 0);
        repeat (100) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
